// ===== rtl/integer_add_sub_mul_div_mod_unit_assert.svh =====
// assertion macros for the integer add/sub/mul/div/mod unit
// no dependencies; included by the modules that carry assertions
`ifndef INTEGER_ADD_SUB_MUL_DIV_MOD_UNIT_ASSERT_SVH
`define INTEGER_ADD_SUB_MUL_DIV_MOD_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define IASMDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under reset
`define IASMDM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/iasmdm_pkg.sv =====
// shared types and codes for the integer add/sub/mul/div/mod unit
// no dependencies
package iasmdm_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef logic [2:0] func_t;

  localparam func_t FUNC_ADD = 3'd0;
  localparam func_t FUNC_SUB = 3'd1;
  localparam func_t FUNC_MUL = 3'd2;
  localparam func_t FUNC_DIV = 3'd3;
  localparam func_t FUNC_REM = 3'd4;

endpackage

// ===== rtl/integer_add_sub_mul_div_mod_unit.sv =====
// add, sub, mul, div and rem step through S_RUN one bit per cycle through the operand shift
// registers, then go to S_FIX; a zero divisor or an unused code goes from S_IDLE to S_FIX.
// S_FIX waits while the output register holds a result not yet taken. a new item is accepted
// only in S_IDLE, after the last one has left S_FIX. the output register holds a finished result
// while the next item is accepted. reset (rst_n low, synchronous) empties the unit.
// uses iasmdm_pkg and integer_add_sub_mul_div_mod_unit_assert.svh
`include "integer_add_sub_mul_div_mod_unit_assert.svh"

module integer_add_sub_mul_div_mod_unit #(
  parameter int DATA_WIDTH = iasmdm_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  iasmdm_pkg::func_t            in_func,
  input  logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_result,
  output logic                         out_div_by_zero
);
  import iasmdm_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] ONE_W = DATA_WIDTH'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  func_t                 op_r, op_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  carry_r, carry_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_rem_r, neg_rem_nxt;
  logic                  dz_r, dz_nxt;
  logic                  zero_r, zero_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_result_r, out_result_nxt;
  logic                  out_dz_r, out_dz_nxt;

  logic                  in_fire;
  logic                  in_is_div;
  logic                  in_dz;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] mul_sum;
  logic                  b_bit;
  logic                  sum_bit;
  logic [DATA_WIDTH-1:0] fin;

  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_div_by_zero = out_dz_r;

  // operand magnitudes for the divider
  assign mag_a = in_operand_a[DATA_WIDTH-1] ? (~in_operand_a + ONE_W) : in_operand_a;
  assign mag_b = in_operand_b[DATA_WIDTH-1] ? (~in_operand_b + ONE_W) : in_operand_b;
  assign in_is_div = (in_func == FUNC_DIV) || (in_func == FUNC_REM);
  assign in_dz = in_is_div && (in_operand_b == '0);

  // restoring divide trial subtract and shift-add partial sum
  assign trial   = {acc_r, a_r[DATA_WIDTH-1]} - {1'b0, b_r};
  assign mul_sum = acc_r + (a_r[0] ? b_r : '0);

  // bit-serial add/sub on the low bits
  assign b_bit   = b_r[0] ^ (op_r == FUNC_SUB);
  assign sum_bit = a_r[0] ^ b_bit ^ carry_r;

  // sign fix and final select
  always_comb begin
    fin = '0;
    if (!zero_r) begin
      unique case (op_r)
        FUNC_ADD, FUNC_SUB, FUNC_MUL: fin = acc_r;
        FUNC_DIV: fin = neg_q_r ? (~a_r + ONE_W) : a_r;
        FUNC_REM: fin = neg_rem_r ? (~acc_r + ONE_W) : acc_r;
        default:  fin = '0;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    carry_nxt      = carry_r;
    neg_q_nxt      = neg_q_r;
    neg_rem_nxt    = neg_rem_r;
    dz_nxt         = dz_r;
    zero_nxt       = zero_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_result_nxt = out_result_r;
    out_dz_nxt     = out_dz_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_func;
          cnt_nxt     = '0;
          acc_nxt     = '0;
          carry_nxt   = (in_func == FUNC_SUB);
          neg_q_nxt   = in_operand_a[DATA_WIDTH-1] ^ in_operand_b[DATA_WIDTH-1];
          neg_rem_nxt = in_operand_a[DATA_WIDTH-1];
          dz_nxt      = in_dz;
          zero_nxt    = in_dz || (in_func > FUNC_REM);
          a_nxt       = in_is_div ? mag_a : in_operand_a;
          b_nxt       = in_is_div ? mag_b : in_operand_b;
          state_nxt   = (in_dz || (in_func > FUNC_REM)) ? S_FIX : S_RUN;
        end
      end
      S_RUN: begin
        unique case (op_r)
          FUNC_ADD, FUNC_SUB: begin
            carry_nxt = (a_r[0] & b_bit) | (a_r[0] & carry_r) | (b_bit & carry_r);
            acc_nxt   = {sum_bit, acc_r[DATA_WIDTH-1:1]};
            a_nxt     = a_r >> 1;
            b_nxt     = b_r >> 1;
          end
          FUNC_MUL: begin
            acc_nxt = mul_sum;
            a_nxt   = a_r >> 1;
            b_nxt   = b_r << 1;
          end
          FUNC_DIV, FUNC_REM: begin
            if (!trial[DATA_WIDTH]) begin
              acc_nxt = trial[DATA_WIDTH-1:0];
            end else begin
              acc_nxt = {acc_r[DATA_WIDTH-2:0], a_r[DATA_WIDTH-1]};
            end
            a_nxt = {a_r[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
          end
          default: begin
            acc_nxt = acc_r;
          end
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = fin;
          out_dz_nxt     = dz_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    acc_r        <= acc_nxt;
    cnt_r        <= cnt_nxt;
    carry_r      <= carry_nxt;
    neg_q_r      <= neg_q_nxt;
    neg_rem_r    <= neg_rem_nxt;
    dz_r         <= dz_nxt;
    zero_r       <= zero_nxt;
    out_result_r <= out_result_nxt;
    out_dz_r     <= out_dz_nxt;
  end

  // checks
  `IASMDM_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)
  `IASMDM_ASSERT_IMP(a_dz_gives_zero, clk, rst_n, out_valid && out_div_by_zero, out_result == '0)
  `IASMDM_ASSERT_IMP(a_run_count, clk, rst_n, state_r == S_RUN, cnt_r <= CNT_LAST)
  `IASMDM_ASSERT_NXT(a_out_drains, clk, rst_n, out_valid && out_ready && state_r != S_FIX, !out_valid)

endmodule
